// ----- rtl/cyc2515_pkg.sv -----
// Package for the (25,15) cyclic-code check and map block.
// Holds field widths, status and kind codes, and the GF(2) division steps.
// No dependencies.
`timescale 1ns / 1ps

package cyc2515_pkg;

    localparam int CODE_LEN    = 25;
    localparam int MSG_LEN     = 15;
    localparam int CHK_LEN     = 11;
    localparam int REM_W       = CHK_LEN - 1;
    localparam int BASES_W     = 2 * CODE_LEN;
    localparam int IDX_W       = 15;
    localparam int FRONT_STEPS = 8;
    localparam int BACK_STEPS  = MSG_LEN - FRONT_STEPS;
    localparam int TAIL_W      = CODE_LEN - CHK_LEN - FRONT_STEPS;

    // generator 1,1,1,0,1,1,0,1,0,0,1 with the first tap as bit 0
    localparam logic [CHK_LEN-1:0] GEN_MASK = 11'h4B7;

    localparam logic [IDX_W-1:0] MAX_INDEX_RESET = 15'd29988;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_DECODE = 1'b1;

    localparam logic [1:0] STAT_MATCH = 2'd0;
    localparam logic [1:0] STAT_REM   = 2'd1;
    localparam logic [1:0] STAT_MISS  = 2'd2;

    typedef struct packed {
        logic [CHK_LEN-1:0]     win;
        logic [FRONT_STEPS-1:0] quo;
    } front_t;

    typedef struct packed {
        logic [BACK_STEPS-1:0] quo;
        logic [REM_W-1:0]      rem;
    } back_t;

    // First division steps: quotient bits 0..7 and the running window
    function automatic front_t div_front(input logic [CODE_LEN-1:0] code);
        logic [CHK_LEN-1:0]     win;
        logic [CHK_LEN-1:0]     r;
        logic [FRONT_STEPS-1:0] quo;
        front_t                 res;
        win = code[CHK_LEN-1:0];
        quo = '0;
        for (int i = 0; i < FRONT_STEPS; i++) begin
            quo[i] = win[0];
            r      = win[0] ? (win ^ GEN_MASK) : win;
            win    = {code[i+CHK_LEN], r[CHK_LEN-1:1]};
        end
        res.win = win;
        res.quo = quo;
        return res;
    endfunction

    // Remaining division steps: quotient bits 8..14 and the remainder
    function automatic back_t div_back(input logic [CHK_LEN-1:0] win_in,
                                       input logic [TAIL_W-1:0]  tail);
        logic [CHK_LEN-1:0]    win;
        logic [CHK_LEN-1:0]    r;
        logic [BACK_STEPS-1:0] quo;
        back_t                 res;
        win = win_in;
        quo = '0;
        r   = '0;
        for (int i = 0; i < BACK_STEPS; i++) begin
            quo[i] = win[0];
            r      = win[0] ? (win ^ GEN_MASK) : win;
            if (i < TAIL_W) begin
                win = {tail[i], r[CHK_LEN-1:1]};
            end
        end
        res.quo = quo;
        res.rem = r[CHK_LEN-1:1];
        return res;
    endfunction

endpackage

// ----- rtl/cyclic_25_15_check_and_map.sv -----
// Top level of the (25,15) cyclic-code check and map block.
// Depends on cyc2515_pkg (widths, codes, division steps).
`timescale 1ns / 1ps
//
// Usage:
//   s_ channel: one transaction per item. s_kind = 0 writes s_entry_value
//   into the map at s_entry_addr and gives no result. s_kind = 1 decodes the
//   25-base window on s_bases and gives one result on the m_ channel.
//   cfg channel: cfg_data writes max_index; cfg_ready is high whenever the
//   block is out of reset. Write it only while no decode is in flight.
//   m_ channel: status (match, nonzero remainder, map miss), the 15-bit
//   message and the record number on a match.
// Path: an item passes through stage 1, then stage 2 with the map read, then the output register.
// Throughput: one item per cycle while m_ready is high; the map is a single-port
//   memory and each item makes exactly one access to it.
// Reset: synchronous, active low. After reset a clearing pass zeroes the map
//   one entry a cycle over all MAP_DEPTH (32768) entries; s_ready stays low then,
//   while configuration writes are taken as usual.
// Stall: the result register holds while m_ready is low; the two pipeline
//   stages behind it fill, then s_ready drops.
// A write followed by a decode of the same message sees the new entry.

module cyclic_25_15_check_and_map
    import cyc2515_pkg::*;
#(
    parameter int MAP_DEPTH = 32768
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic [BASES_W-1:0] s_bases,
    input  logic [IDX_W-1:0]   s_entry_addr,
    input  logic [IDX_W-1:0]   s_entry_value,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [IDX_W-1:0]   cfg_data,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_result_status,
    output logic [MSG_LEN-1:0] m_message_value,
    output logic [IDX_W-1:0]   m_mapped_index
);

    localparam int ADDR_W = $clog2(MAP_DEPTH);

    // Map memory and its registered read port
    logic [IDX_W-1:0] code_map [MAP_DEPTH];
    logic [IDX_W-1:0] map_q_reg;

    // Control registers
    logic              clearing_reg, clearing_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [IDX_W-1:0]  max_index_reg;
    logic              cfg_ready_reg;
    logic              p1_valid_reg;
    logic              p2_valid_reg;
    logic              m_valid_reg;

    // Stage 1 payload: front half of the division or a map write
    logic                   p1_kind_reg;
    logic [CHK_LEN-1:0]     p1_win_reg;
    logic [FRONT_STEPS-1:0] p1_quo_reg;
    logic [TAIL_W-1:0]      p1_tail_reg;
    logic [IDX_W-1:0]       p1_addr_reg;
    logic [IDX_W-1:0]       p1_val_reg;

    // Stage 2 payload: finished quotient and syndrome flag
    logic [MSG_LEN-1:0] p2_msg_reg;
    logic               p2_rem_nz_reg;

    // Output register payload
    logic [1:0]         out_status_reg;
    logic [MSG_LEN-1:0] out_msg_reg;
    logic [IDX_W-1:0]   out_mapped_reg;

    logic [CODE_LEN-1:0] s_code;
    front_t              front;
    back_t               back;
    logic [MSG_LEN-1:0]  p1_msg;
    logic                s_fire;
    logic                p1_go;
    logic                p2_go;
    logic                clr_last;
    logic                mem_we;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_addr;
    logic [IDX_W-1:0]    mem_wdata;
    logic [1:0]          status_calc;
    logic [IDX_W-1:0]    mapped_calc;

    // Code bits: low bit of each base code
    always_comb begin
        for (int j = 0; j < CODE_LEN; j++) begin
            s_code[j] = s_bases[2*j];
        end
    end

    assign front  = div_front(s_code);
    assign back   = div_back(p1_win_reg, p1_tail_reg);
    assign p1_msg = {back.quo, p1_quo_reg};

    // Pipeline handshake
    assign p2_go   = p2_valid_reg && (!m_valid_reg || m_ready);
    assign p1_go   = p1_valid_reg &&
                     ((p1_kind_reg == KIND_WRITE) || !p2_valid_reg || p2_go);
    assign s_ready = !clearing_reg && (!p1_valid_reg || p1_go);
    assign s_fire  = s_valid && s_ready;

    assign cfg_ready = cfg_ready_reg;

    // Clearing pass after reset
    assign clr_last      = (clr_addr_reg == ADDR_W'(MAP_DEPTH - 1));
    assign clearing_next = clearing_reg && !clr_last;
    assign clr_addr_next = clr_addr_reg + ADDR_W'(1);

    // Single memory port: clear, write or read
    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = p1_msg[ADDR_W-1:0];
        mem_wdata = p1_val_reg;
        if (clearing_reg) begin
            mem_we    = 1'b1;
            mem_addr  = clr_addr_reg;
            mem_wdata = '0;
        end else if (p1_go) begin
            if (p1_kind_reg == KIND_WRITE) begin
                mem_we   = 1'b1;
                mem_addr = p1_addr_reg[ADDR_W-1:0];
            end else begin
                mem_re = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            code_map[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            map_q_reg <= code_map[mem_addr];
        end
    end

    // Result classification from the read entry
    always_comb begin
        mapped_calc = '0;
        if (p2_rem_nz_reg) begin
            status_calc = STAT_REM;
        end else if ((map_q_reg != '0) && (map_q_reg <= max_index_reg)) begin
            status_calc = STAT_MATCH;
            mapped_calc = map_q_reg;
        end else begin
            status_calc = STAT_MISS;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            max_index_reg <= MAX_INDEX_RESET;
            cfg_ready_reg <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            cfg_ready_reg <= 1'b1;
            if (clearing_reg) begin
                clearing_reg <= clearing_next;
                clr_addr_reg <= clr_addr_next;
            end
            if (cfg_valid && cfg_ready) begin
                max_index_reg <= cfg_data;
            end
            if (s_fire) begin
                p1_valid_reg <= 1'b1;
            end else if (p1_go) begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_go && (p1_kind_reg == KIND_DECODE)) begin
                p2_valid_reg <= 1'b1;
            end else if (p2_go) begin
                p2_valid_reg <= 1'b0;
            end
            if (p2_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            p1_kind_reg <= s_kind;
            p1_win_reg  <= front.win;
            p1_quo_reg  <= front.quo;
            p1_tail_reg <= s_code[CODE_LEN-1:CODE_LEN-TAIL_W];
            p1_addr_reg <= s_entry_addr;
            p1_val_reg  <= s_entry_value;
        end
        if (p1_go && (p1_kind_reg == KIND_DECODE)) begin
            p2_msg_reg    <= p1_msg;
            p2_rem_nz_reg <= |back.rem;
        end
        if (p2_go) begin
            out_status_reg <= status_calc;
            out_msg_reg    <= p2_msg_reg;
            out_mapped_reg <= mapped_calc;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_result_status = out_status_reg;
    assign m_message_value = out_msg_reg;
    assign m_mapped_index  = out_mapped_reg;

`ifndef ASSERT_OFF
    // No transaction taken while the map is being cleared
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !s_ready)
        else $error("input accepted during clearing pass");

    // One memory access per cycle
    a_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("map read and write in the same cycle");

    // A stage 2 hand-off always lands in the output register
    a_p2_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        p2_go |=> m_valid_reg)
        else $error("decoded item lost between stage 2 and output");

    // A match carries a record number in range
    a_match_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (out_status_reg == STAT_MATCH)) |->
            ((out_mapped_reg != '0) && (out_mapped_reg <= max_index_reg)))
        else $error("match with out-of-range record number");

    // Any other status carries no record number
    a_nomatch_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (out_status_reg != STAT_MATCH)) |-> (out_mapped_reg == '0))
        else $error("record number on a non-match result");
`endif

endmodule
